// ===== design/soct_pkg.sv =====
// Shared constants and state codes for the sparse octree builder.
package soct_pkg;

  localparam int DEF_MAX_DEPTH  = 4;
  localparam int DEF_INDEX_BITS = 16;
  localparam int MORTON_W       = 12;
  localparam int CFG_W          = 3;
  localparam int MASK_W         = 8;
  localparam int SLOT_W         = 3;
  localparam int FILL_W         = 4;
  localparam logic [CFG_W-1:0]  DEPTH_RST = 3'd4;
  localparam logic [FILL_W-1:0] FILL_LAST = 4'd7;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GAP   = 9'b000000010,
    S_LEAF  = 9'b000000100,
    S_CRD   = 9'b000001000,
    S_CCHK  = 9'b000010000,
    S_CPAR  = 9'b000100000,
    S_RRD   = 9'b001000000,
    S_ROOT  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

endpackage

// ===== design/soct_if.sv =====
// Handshake channels for voxel commands and emitted nodes.
interface soct_in_if
  import soct_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [MORTON_W-1:0] morton_code;

  modport source (output valid, cmd, morton_code, input ready);
  modport sink   (input valid, cmd, morton_code, output ready);
endinterface

interface soct_out_if
  import soct_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] node_index;
  logic                  is_leaf;
  logic [INDEX_BITS-1:0] child_base;
  logic [MASK_W-1:0]     child_mask;
  logic                  is_root;
  logic                  error;
  logic                  last;

  modport source (output valid, node_index, is_leaf, child_base, child_mask, is_root,
                  error, last, input ready);
  modport sink   (input valid, node_index, is_leaf, child_base, child_mask, is_root,
                  error, last, output ready);
endinterface

// ===== design/soct_node_mem.sv =====
// Per-level node queues: one write port, one registered read port.
module soct_node_mem
  import soct_pkg::*;
#(
  parameter int AW = 6,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/soct_blk.sv =====
// Sizes the largest aligned empty block that fits at the head of a gap.
module soct_blk
  import soct_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int NM_W      = 3 * MAX_DEPTH + 1,
  parameter int LVL_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic [NM_W-1:0]  nm,
  input  logic [NM_W-1:0]  gap,
  input  logic [LVL_W-1:0] depth,
  output logic [LVL_W-1:0] k,
  output logic [NM_W-1:0]  blk
);
  always_comb begin
    logic            go;
    logic [NM_W-1:0] nb;
    go = 1'b1;
    k  = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      nb = NM_W'(1) << (3 * (j + 1));
      if (go && (LVL_W'(j) < depth) && ((nm & (nb - NM_W'(1))) == '0) && (nb <= gap)) begin
        k = k + LVL_W'(1);
      end else begin
        go = 1'b0;
      end
    end
    blk = NM_W'(1) << (3 * k);
  end
endmodule

// ===== design/sparse_octree_bottom_up_builder_unit.sv =====
// Sparse voxel octree builder: voxels in rising Morton order in, octree nodes out.
// One item is taken at a time. An add is accepted, then fills the gap with empty aligned
// blocks, one block at a time, until it finds the gap closed, then writes the leaf; each
// level that collapses reads its eight children in turn through the queue memory's
// registered read port, checking each after its read, and then writes the parent; last the
// final result is handed over. A finish reads the root where an add writes the leaf. A
// rejected voxel yields an error result that is handed over at once. A stalled output stretches all of this.
// The node queues are one memory of 8 entries per level, read one child at a time.
module sparse_octree_bottom_up_builder_unit
  import soct_pkg::*;
#(
  parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  soct_in_if.sink          voxel,
  soct_out_if.source       node
);
  localparam int NM_W  = 3 * MAX_DEPTH + 1;
  localparam int CMP_W = (NM_W > MORTON_W) ? NM_W : MORTON_W;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int AW    = LVL_W + SLOT_W;
  localparam int DW    = 1 + INDEX_BITS + MASK_W;

  state_t state;
  logic [CFG_W-1:0]      gdepth;
  logic [FILL_W-1:0]     fill [0:MAX_DEPTH];
  logic [NM_W-1:0]       nm;
  logic [NM_W-1:0]       target;
  logic [INDEX_BITS-1:0] cnt;
  logic                  is_fin;
  logic                  ret_flush;
  logic [LVL_W-1:0]      cl;
  logic [SLOT_W-1:0]     c;
  logic [MASK_W-1:0]     pmask;
  logic [INDEX_BITS-1:0] pbase;

  // pending result (last unknown yet) and output register
  logic                  hv;
  logic [INDEX_BITS-1:0] h_idx, h_base;
  logic                  h_leaf, h_root, h_err;
  logic [MASK_W-1:0]     h_mask;
  logic                  o_vld;
  logic [INDEX_BITS-1:0] o_idx, o_base;
  logic                  o_leaf, o_root, o_err, o_last;
  logic [MASK_W-1:0]     o_mask;

  logic [LVL_W-1:0] depth;
  logic [NM_W-1:0]  size;
  logic [CMP_W-1:0] code_x;
  logic             bad;
  logic             in_acc;
  logic             slot;
  logic [NM_W-1:0]  gap;
  logic             gap_nz;
  logic [LVL_W-1:0] k;
  logic [NM_W-1:0]  blk;

  logic             push_en;
  logic [LVL_W-1:0] push_lvl;
  logic [DW-1:0]    push_node;
  logic             push_ok;
  logic             we;
  logic             coll;
  logic [AW-1:0]    raddr;
  logic [DW-1:0]    rdata;
  logic             rd_leaf;
  logic [INDEX_BITS-1:0] rd_base;
  logic [MASK_W-1:0] rd_mask;
  logic             chk_null;

  logic                  prod;
  logic [INDEX_BITS-1:0] r_idx, r_base;
  logic                  r_leaf, r_root, r_err;
  logic [MASK_W-1:0]     r_mask;
  logic                  flush_go;
  logic                  o_load;

  always_comb begin
    if (gdepth == '0) begin
      depth = LVL_W'(1);
    end else if (32'(gdepth) > MAX_DEPTH) begin
      depth = LVL_W'(MAX_DEPTH);
    end else begin
      depth = LVL_W'(gdepth);
    end
  end

  assign size     = NM_W'(1) << (3 * depth);
  assign code_x   = CMP_W'(voxel.morton_code);
  assign bad      = (code_x < CMP_W'(nm)) || (code_x >= CMP_W'(size));
  assign in_acc   = voxel.valid && voxel.ready;
  assign voxel.ready = (state == S_IDLE);
  assign slot     = !o_vld || node.ready;
  assign gap      = target - nm;
  assign gap_nz   = (nm < target);

  soct_blk #(.MAX_DEPTH(MAX_DEPTH), .NM_W(NM_W), .LVL_W(LVL_W)) u_blk (
    .nm    (nm),
    .gap   (gap),
    .depth (depth),
    .k     (k),
    .blk   (blk)
  );

  always_comb begin
    push_en   = 1'b0;
    push_lvl  = depth;
    push_node = '0;
    case (state)
      S_GAP: begin
        push_en  = gap_nz;
        push_lvl = depth - k;
      end
      S_LEAF: begin
        push_en   = 1'b1;
        push_node = {1'b1, {INDEX_BITS{1'b0}}, {MASK_W{1'b0}}};
      end
      S_CPAR: begin
        push_en   = 1'b1;
        push_lvl  = cl - LVL_W'(1);
        push_node = {1'b0, pbase, pmask};
      end
      default: ;
    endcase
  end

  assign push_ok = !fill[push_lvl][FILL_W-1];
  assign we      = push_en && push_ok;
  assign coll    = we && (fill[push_lvl] == FILL_LAST) && (push_lvl != '0);
  assign raddr   = ((state == S_RRD) || (state == S_ROOT)) ? '0 : {cl, c};

  soct_node_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr ({push_lvl, fill[push_lvl][SLOT_W-1:0]}),
    .wdata (push_node),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_leaf  = rdata[DW-1];
  assign rd_base  = rdata[MASK_W +: INDEX_BITS];
  assign rd_mask  = rdata[MASK_W-1:0];
  assign chk_null = !rd_leaf && (rd_mask == '0);

  always_comb begin
    prod   = 1'b0;
    r_idx  = cnt;
    r_leaf = 1'b0;
    r_base = '0;
    r_mask = '0;
    r_root = 1'b0;
    r_err  = 1'b0;
    case (state)
      S_IDLE: begin
        prod  = in_acc && (voxel.cmd == CMD_ADD) && bad;
        r_idx = '0;
        r_err = 1'b1;
      end
      S_CCHK: begin
        prod   = !chk_null && slot;
        r_leaf = rd_leaf;
        r_base = rd_base;
        r_mask = rd_mask;
      end
      S_ROOT: begin
        prod   = slot;
        r_root = 1'b1;
        if (fill[0] != '0) begin
          r_leaf = rd_leaf;
          r_base = rd_base;
          r_mask = rd_mask;
        end
      end
      default: ;
    endcase
  end

  assign flush_go = (state == S_FLUSH) && hv && slot;
  assign o_load   = (prod && hv) || flush_go;

  // Hold each result until the next one shows whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      hv    <= 1'b0;
    end else begin
      if (o_load) begin
        o_vld <= 1'b1;
      end else if (node.ready) begin
        o_vld <= 1'b0;
      end
      if (prod) begin
        if (hv) begin
          o_idx  <= h_idx;
          o_leaf <= h_leaf;
          o_base <= h_base;
          o_mask <= h_mask;
          o_root <= h_root;
          o_err  <= h_err;
          o_last <= 1'b0;
        end
        hv     <= 1'b1;
        h_idx  <= r_idx;
        h_leaf <= r_leaf;
        h_base <= r_base;
        h_mask <= r_mask;
        h_root <= r_root;
        h_err  <= r_err;
      end else if (flush_go) begin
        o_idx  <= h_idx;
        o_leaf <= h_leaf;
        o_base <= h_base;
        o_mask <= h_mask;
        o_root <= h_root;
        o_err  <= h_err;
        o_last <= 1'b1;
        hv     <= 1'b0;
      end
    end
  end

  assign node.valid      = o_vld;
  assign node.node_index = o_idx;
  assign node.is_leaf    = o_leaf;
  assign node.child_base = o_base;
  assign node.child_mask = o_mask;
  assign node.is_root    = o_root;
  assign node.error      = o_err;
  assign node.last       = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gdepth    <= DEPTH_RST;
      nm        <= '0;
      cnt       <= '0;
      is_fin    <= 1'b0;
      ret_flush <= 1'b0;
      cl        <= '0;
      c         <= '0;
      pmask     <= '0;
      for (int i = 0; i <= MAX_DEPTH; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        gdepth <= cfg_wdata;
        nm     <= '0;
        cnt    <= '0;
        for (int i = 0; i <= MAX_DEPTH; i++) begin
          fill[i] <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (voxel.cmd == CMD_ADD) begin
              if (bad) begin
                state <= S_FLUSH;
              end else begin
                target <= code_x[NM_W-1:0];
                is_fin <= 1'b0;
                state  <= S_GAP;
              end
            end else begin
              target <= size;
              is_fin <= 1'b1;
              state  <= S_GAP;
            end
          end
        end
        S_GAP: begin
          if (gap_nz) begin
            nm        <= nm + blk;
            ret_flush <= 1'b0;
            state     <= coll ? S_CRD : S_GAP;
          end else begin
            state <= is_fin ? S_RRD : S_LEAF;
          end
        end
        S_LEAF: begin
          nm        <= nm + NM_W'(1);
          ret_flush <= 1'b1;
          state     <= coll ? S_CRD : S_FLUSH;
        end
        S_CRD: begin
          state <= S_CCHK;
        end
        S_CCHK: begin
          if (chk_null || slot) begin
            if (prod) begin
              cnt <= cnt + INDEX_BITS'(1);
              if (pmask == '0) begin
                pbase <= cnt;
              end
              pmask[c] <= 1'b1;
            end
            if (c == SLOT_W'(FILL_LAST)) begin
              state <= S_CPAR;
            end else begin
              c     <= c + SLOT_W'(1);
              state <= S_CRD;
            end
          end
        end
        S_CPAR: begin
          fill[cl] <= '0;
          state    <= coll ? S_CRD : (ret_flush ? S_FLUSH : S_GAP);
        end
        S_RRD: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (slot) begin
            nm  <= '0;
            cnt <= '0;
            for (int i = 0; i <= MAX_DEPTH; i++) begin
              fill[i] <= '0;
            end
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!hv || slot) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // queue push; a collapse starts on the level that just filled
      if (we) begin
        fill[push_lvl] <= fill[push_lvl] + FILL_W'(1);
      end
      if (coll) begin
        cl    <= push_lvl;
        c     <= '0;
        pmask <= '0;
        pbase <= '0;
      end
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hv)
    else $error("pending result left over while idle");

  a_no_root_collapse: assert property (@(posedge clk) disable iff (rst)
    (state == S_CCHK) |-> (cl != '0))
    else $error("collapse started on the root level");

  a_prod_has_room: assert property (@(posedge clk) disable iff (rst)
    (prod && hv) |-> slot)
    else $error("result produced with output register busy");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && !hv) |=> (state == S_IDLE))
    else $error("flush did not return to idle");

endmodule
